// ===== hdl/uisl_pkg.sv =====
// ----------------------------------------------------------------------------
// uisl_pkg
// Shared sizes, codes and command type of the interval list union block.
// ----------------------------------------------------------------------------
package uisl_pkg;

  localparam int SEQUENCES  = 8;
  localparam int LIST_DEPTH = 256;

  localparam int SEL_W   = (SEQUENCES > 1) ? $clog2(SEQUENCES) : 1;
  localparam int FILL_W  = $clog2(LIST_DEPTH + 1);
  localparam int SCAN_W  = $clog2(SEQUENCES + 1);
  localparam int ADDR_W  = (SEQUENCES * LIST_DEPTH > 1) ? $clog2(SEQUENCES * LIST_DEPTH) : 1;
  localparam int WORDS   = SEQUENCES * LIST_DEPTH;
  localparam int WORD_W  = 128;

  typedef logic [SEL_W-1:0]  sel_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [SCAN_W-1:0] scan_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_PULL  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PULL,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        idx_ok;
    sel_t        idx;
    logic [63:0] start;
    logic [63:0] stop;
  } cmd_t;

  function automatic addr_t ram_addr(sel_t s, fill_t p);
    return addr_t'(s) * addr_t'(LIST_DEPTH) + addr_t'(p);
  endfunction

endpackage

// ===== hdl/uisl_if.sv =====
// ----------------------------------------------------------------------------
// uisl_if
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
interface uisl_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  list_index;
  logic [63:0] interval_start;
  logic [63:0] interval_end;

  modport source (output valid, func, list_index, interval_start, interval_end,
                  input ready);
  modport sink   (input valid, func, list_index, interval_start, interval_end,
                  output ready);
endinterface

interface uisl_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        out_valid;
  logic [63:0] out_start;
  logic [63:0] out_end;
  logic [63:0] running_length;

  modport source (output valid, status, out_valid, out_start, out_end, running_length,
                  input ready);
  modport sink   (input valid, status, out_valid, out_start, out_end, running_length,
                  output ready);
endinterface

// ===== hdl/uisl_ram.sv =====
// ----------------------------------------------------------------------------
// uisl_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module uisl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/uisl_front.sv =====
// ----------------------------------------------------------------------------
// uisl_front
// Accepts items, decodes the function and queues commands for the back end.
// ----------------------------------------------------------------------------
module uisl_front import uisl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  uisl_item_if.sink   item,
  output cmd_t        cmd,
  output logic        cmd_valid,
  input  logic        cmd_pop
);

  cmd_t        queue [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  cmd_t        incoming;
  logic        push;

  always_comb begin
    incoming.idx    = sel_t'(item.list_index);
    incoming.idx_ok = {29'd0, item.list_index} < 32'(SEQUENCES);
    incoming.start  = item.interval_start;
    incoming.stop   = item.interval_end;
    unique case (item.func)
      FUNC_LOAD:  incoming.op = OP_LOAD;
      FUNC_PULL:  incoming.op = OP_PULL;
      FUNC_CLEAR: incoming.op = OP_CLEAR;
      default:    incoming.op = OP_NOP;
    endcase
  end

  assign item.ready = (count != 2'd2);
  assign push       = item.valid && item.ready;
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

// ===== hdl/uisl_back.sv =====
// ----------------------------------------------------------------------------
// uisl_back
// Executes loads, clears and pulls; a pull scans list heads in RAM and
// merges overlapping intervals before writing one result beat.
// ----------------------------------------------------------------------------
module uisl_back import uisl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  uisl_res_if.source  res
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t       state;
  fill_t        fc [SEQUENCES];
  fill_t        rp [SEQUENCES];
  scan_t        cnt;
  logic         rd_live;
  logic         best_ok;
  sel_t         best_idx;
  sel_t         rd_tag;
  logic [63:0]  best_start;
  logic [63:0]  best_stop;
  logic         pend_valid;
  logic [63:0]  pend_start;
  logic [63:0]  pend_stop;
  logic [63:0]  total;
  logic [63:0]  total_next;

  logic         res_vld;
  logic [1:0]   res_status;
  logic         res_out_valid;
  logic [63:0]  res_start;
  logic [63:0]  res_stop;
  logic [63:0]  res_len;

  sel_t         rsel;
  fill_t        fc_sel;
  fill_t        rp_sel;
  logic         ram_we;
  addr_t        waddr;
  addr_t        raddr;
  logic [WORD_W-1:0] rdata;
  logic         load_ok;

  always_comb begin
    unique case (state)
      S_IDLE:   rsel = cmd.idx;
      S_DECIDE: rsel = best_idx;
      default:  rsel = cnt[SEL_W-1:0];
    endcase
  end

  assign fc_sel     = fc[rsel];
  assign rp_sel     = rp[rsel];
  assign cmd_pop    = (state == S_IDLE) && cmd_valid && !res_vld;
  assign load_ok    = cmd.idx_ok && (fc_sel < fill_t'(LIST_DEPTH));
  assign ram_we     = cmd_pop && (cmd.op == OP_LOAD) && load_ok;
  assign waddr      = ram_addr(cmd.idx, fc_sel);
  assign raddr      = ram_addr(rsel, rp_sel);
  assign total_next = total + (pend_stop - pend_start);

  uisl_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({cmd.start, cmd.stop}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign res.valid          = res_vld;
  assign res.status         = res_status;
  assign res.out_valid      = res_out_valid;
  assign res.out_start      = res_start;
  assign res.out_end        = res_stop;
  assign res.running_length = res_len;

  // head comparison, one list a cycle; strict less keeps the lower index on ties
  always_ff @(posedge clk) begin
    if (rd_live && (!best_ok || rdata[127:64] < best_start)) begin
      best_idx   <= rd_tag;
      best_start <= rdata[127:64];
      best_stop  <= rdata[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_vld    <= 1'b0;
      rd_live    <= 1'b0;
      best_ok    <= 1'b0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      total      <= '0;
      for (int s = 0; s < SEQUENCES; s++) begin
        fc[s] <= '0;
        rp[s] <= '0;
      end
    end else begin
      if (res.valid && res.ready) begin
        res_vld <= 1'b0;
      end
      if (rd_live) begin
        best_ok <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            res_out_valid <= 1'b0;
            res_start     <= '0;
            res_stop      <= '0;
            res_len       <= total;
            res_status    <= ST_OK;
            case (cmd.op)
              OP_LOAD: begin
                res_vld <= 1'b1;
                if (load_ok) begin
                  fc[cmd.idx] <= fc_sel + fill_t'(1);
                end else begin
                  res_status <= ST_OVERFLOW;
                end
              end
              OP_PULL: begin
                pend_valid <= 1'b0;
                best_ok    <= 1'b0;
                rd_live    <= 1'b0;
                cnt        <= '0;
                state      <= S_SCAN;
              end
              OP_CLEAR: begin
                res_vld    <= 1'b1;
                pend_valid <= 1'b0;
                for (int s = 0; s < SEQUENCES; s++) begin
                  fc[s] <= '0;
                  rp[s] <= '0;
                end
              end
              default: begin
                res_vld <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (cnt < scan_t'(SEQUENCES)) begin
            rd_live <= rp_sel < fc_sel;
            rd_tag  <= cnt[SEL_W-1:0];
            cnt     <= cnt + scan_t'(1);
          end else begin
            rd_live <= 1'b0;
            state   <= S_DECIDE;
          end
        end
        default: begin
          if (best_ok && (!pend_valid || best_start <= pend_stop)) begin
            // absorb the smallest head and rescan
            if (!pend_valid) begin
              pend_start <= best_start;
              pend_stop  <= best_stop;
            end else if (best_stop > pend_stop) begin
              pend_stop <= best_stop;
            end
            pend_valid <= 1'b1;
            rp[rsel]   <= rp_sel + fill_t'(1);
            best_ok    <= 1'b0;
            cnt        <= '0;
            state      <= S_SCAN;
          end else begin
            res_vld <= 1'b1;
            state   <= S_IDLE;
            if (pend_valid) begin
              res_status    <= ST_OK;
              res_out_valid <= 1'b1;
              res_start     <= pend_start;
              res_stop      <= pend_stop;
              res_len       <= total_next;
              total         <= total_next;
              pend_valid    <= 1'b0;
            end else begin
              res_status <= ST_EMPTY;
            end
          end
        end
      endcase
    end
  end

  a_pop_needs_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !res_vld) else $error("command taken while a result is pending");

  a_write_within_list: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> fc_sel < fill_t'(LIST_DEPTH)) else $error("load beyond list depth");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_live |-> state == S_SCAN || state == S_DECIDE) else $error("stray head read");

  a_pull_starts_scan: assert property (@(posedge clk) disable iff (rst)
    cmd_pop && cmd.op == OP_PULL |=> state == S_SCAN) else $error("pull did not scan");

endmodule

// ===== hdl/unite_sorted_interval_lists.sv =====
// ----------------------------------------------------------------------------
// unite_sorted_interval_lists
// Loads sorted interval lists and pulls their union one interval at a time.
// ----------------------------------------------------------------------------
// item channel: func, list_index, interval_start, interval_end; one beat each.
// res channel: status, out_valid, out_start, out_end, running_length; exactly
// one beat for every item, in item order.
// a two-entry command queue parts the front from the back end, so items are
// taken while the back end works or a result waits to be taken.
// load, clear and unused codes pass through the command queue to the result register.
// a pull scans every list head through the RAM read port, one list a cycle,
// and runs one scan per input interval that it merges, plus one final scan.
// the back end takes a new command only once the result register is empty,
// so a stalled receiver holds the block after the queue fills.
// reset (synchronous, active high) empties all lists, the queue and the
// running length; no clearing pass is needed.
// ----------------------------------------------------------------------------
module unite_sorted_interval_lists import uisl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  uisl_item_if.sink  item,
  uisl_res_if.source res
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  uisl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  uisl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .res       (res)
  );

endmodule
